// ===== sv/skpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skpr_pkg: shared types and constants
// Item kinds, front-to-back command format, result layout and register map
// of the serial key pair to keyboard report block.
// ----------------------------------------------------------------------------
package skpr_pkg;

	localparam int TIMEOUT_W = 24;
	localparam int DROP_W    = 32;
	localparam int LEVEL_W   = 6;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 56;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd200000;
	localparam logic [TIMEOUT_W-1:0] AGE_MAX       = 24'hFFFFFF;

	// item kinds on s_tuser
	localparam logic [1:0] FUNC_BYTE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_SLOT = 2'd2;

	// register byte addresses
	localparam logic [1:0] REG_ADDR_TIMEOUT = 2'd0;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_TICK,
		OP_SLOT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       host_ready;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fq_stat_t;

	// first member lands in the highest bits
	typedef struct packed {
		logic               pair_waiting;
		logic [LEVEL_W-1:0] queue_level;
		logic [DROP_W-1:0]  dropped_pairs;
		logic [7:0]         report_modifier;
		logic [7:0]         report_keycode;
		logic               report_valid;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/skpr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skpr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module skpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/skpr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skpr_front: input acceptance and classification
// Decodes each input transfer into a command and holds it in a two-entry
// queue that decouples the input side from the execution side.
// ----------------------------------------------------------------------------
module skpr_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [skpr_pkg::S_DATA_W-1:0]        s_tdata,
	input  wire  [1:0]                           s_tuser,
	output logic                                 cmd_valid,
	output skpr_pkg::cmd_t                       cmd,
	input  wire                                  cmd_ready,
	output skpr_pkg::fq_stat_t                   fq_stat
);
	import skpr_pkg::*;

	localparam logic [1:0] FQ_FULL = 2'd2;

	cmd_t       slot_q [2];
	cmd_t       cmd_in;
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		cmd_in.data_byte  = s_tdata[7:0];
		cmd_in.host_ready = s_tdata[8];
		unique case (s_tuser)
			FUNC_BYTE: cmd_in.op = OP_BYTE;
			FUNC_TICK: cmd_in.op = OP_TICK;
			FUNC_SLOT: cmd_in.op = OP_SLOT;
			default:   cmd_in.op = OP_NOP;
		endcase
	end

	assign s_tready  = (cnt_q != FQ_FULL);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	assign fq_stat.full  = (cnt_q == FQ_FULL);
	assign fq_stat.empty = (cnt_q == 2'd0);

	// clear the slots so the execution side never decodes an unknown command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q[0] <= '0;
			slot_q[1] <= '0;
		end else if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/skpr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skpr_back: command execution
// Pairs bytes, ages half pairs, runs the pair ring queue and the report
// sequencer, and registers one result per command on the output channel.
// ----------------------------------------------------------------------------
module skpr_back #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cmd_valid,
	input  skpr_pkg::cmd_t                       cmd,
	output logic                                 cmd_ready,
	input  wire  [skpr_pkg::TIMEOUT_W-1:0]       timeout_ticks,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output skpr_pkg::result_t                    result
);
	import skpr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_PRESS   = 2'd1;
	localparam logic [1:0] ST_RELEASE = 2'd2;

	logic                 half_q, half_n;
	logic [7:0]           held_q, held_n;
	logic [TIMEOUT_W-1:0] age_q, age_n, age_inc;
	logic                 age_vld_q, age_vld_n;
	logic [PTR_W-1:0]     wp_q, wp_n, wp_inc;
	logic [PTR_W-1:0]     rp_q, rp_n, rp_inc;
	logic [DROP_W-1:0]    drop_q, drop_n;
	logic [1:0]           stage_q, stage_n;
	logic                 we_c, re_c;
	logic [15:0]          pair_rdata;
	logic [PTR_W-1:0]     level_n;
	logic [31:0]          level_ext;
	logic                 take;
	result_t              res_c;
	result_t              out_q;
	logic                 out_vld_q;

	assign cmd_ready = !out_vld_q || m_tready;
	assign take      = cmd_valid && cmd_ready;

	assign wp_inc  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc  = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign age_inc = (age_q != AGE_MAX) ? age_q + 1'b1 : age_q;

	// the popped pair stays in the RAM read register until the next pop
	skpr_ram #(
		.WIDTH (16),
		.DEPTH (QUEUE_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (take && we_c),
		.waddr (wp_q),
		.wdata ({cmd.data_byte, held_q}),
		.re    (take && re_c),
		.raddr (rp_q),
		.rdata (pair_rdata)
	);

	always_comb begin
		half_n    = half_q;
		held_n    = held_q;
		age_n     = age_q;
		age_vld_n = age_vld_q;
		wp_n      = wp_q;
		rp_n      = rp_q;
		drop_n    = drop_q;
		stage_n   = stage_q;
		we_c      = 1'b0;
		re_c      = 1'b0;
		res_c.report_valid    = 1'b0;
		res_c.report_keycode  = 8'd0;
		res_c.report_modifier = 8'd0;

		unique case (cmd.op)
			OP_BYTE: begin
				age_n     = '0;
				age_vld_n = 1'b1;
				if (!half_q) begin
					held_n = cmd.data_byte;
					half_n = 1'b1;
				end else begin
					// a zero keycode pair is neither queued nor counted
					if (held_q != 8'd0) begin
						if (wp_inc == rp_q) begin
							drop_n = drop_q + 1'b1;
						end else begin
							we_c = 1'b1;
							wp_n = wp_inc;
						end
					end
					half_n = 1'b0;
				end
			end
			OP_TICK: begin
				age_n = age_inc;
				if (half_q && age_vld_q && (age_inc > timeout_ticks)) begin
					half_n    = 1'b0;
					held_n    = 8'd0;
					age_vld_n = 1'b0;
				end
			end
			OP_SLOT: begin
				unique case (stage_q)
					ST_PRESS: begin
						if (cmd.host_ready) begin
							res_c.report_valid    = 1'b1;
							res_c.report_keycode  = pair_rdata[7:0];
							res_c.report_modifier = pair_rdata[15:8];
							stage_n = ST_RELEASE;
						end
					end
					ST_RELEASE: begin
						if (cmd.host_ready) begin
							res_c.report_valid = 1'b1;
							stage_n = ST_IDLE;
						end
					end
					default: begin
						// queued pairs always carry a nonzero keycode
						stage_n = ST_IDLE;
						if (rp_q != wp_q) begin
							re_c    = 1'b1;
							rp_n    = rp_inc;
							stage_n = ST_PRESS;
						end
					end
				endcase
			end
			OP_NOP: begin
			end
		endcase

		level_n   = (wp_n >= rp_n) ? wp_n - rp_n : wp_n - rp_n + DEPTH_P;
		level_ext = 32'(level_n);
		res_c.dropped_pairs = drop_n;
		res_c.queue_level   = level_ext[LEVEL_W-1:0];
		res_c.pair_waiting  = half_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= 1'b0;
			held_q    <= 8'd0;
			age_q     <= '0;
			age_vld_q <= 1'b0;
			wp_q      <= '0;
			rp_q      <= '0;
			drop_q    <= '0;
			stage_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				half_q    <= half_n;
				held_q    <= held_n;
				age_q     <= age_n;
				age_vld_q <= age_vld_n;
				wp_q      <= wp_n;
				rp_q      <= rp_n;
				drop_q    <= drop_n;
				stage_q   <= stage_n;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign result   = out_q;

endmodule
`default_nettype wire

// ===== sv/serial_key_pair_to_keyboard_report_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_key_pair_to_keyboard_report_core: key pair to report converter
// Pairs received bytes into keycode and modifier, queues them and emits
// press and release reports on service slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry one event each: s_tuser selects a received byte,
//   a time tick or a report service slot. Every accepted input produces
//   exactly one output transfer with the report fields and status counters.
//   The pair timeout register is to be written over the APB-style port only
//   while the block is idle; the block itself does not enforce this.
//   An accepted input is held in the command queue until the execute stage
//   takes it, and its result is registered in the output stage that drives
//   m_tvalid; throughput is one item per cycle while m_tready does not stall
//   the output stage, set by the execute stage and the single write and read
//   port of the pair RAM.
//   A two-entry command queue sits between input and execution, and a
//   registered output stage holds the result; when m_tready stays low a
//   waiting result stalls execution, the queue takes two more transfers
//   and then s_tready drops.
//   Reset clears pairing state, pointers, counter and report sequencer and
//   sets the timeout to 200000 ticks; the pair RAM needs no clearing since
//   entries are read only after they were written.
// ----------------------------------------------------------------------------
module serial_key_pair_to_keyboard_report_core #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave side
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [7:0] data_byte, [8] host_ready, [15:9] zero
	input  wire  [1:0]  s_tuser,   // [1:0] func
	// master side
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] report_valid, [8:1] report_keycode, [16:9] report_modifier,
	// [48:17] dropped_pairs, [54:49] queue_level, [55] pair_waiting
	output logic [55:0] m_tdata,
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import skpr_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 cmd_valid;
	logic                 cmd_ready;
	cmd_t                 cmd;
	fq_stat_t             fq_stat;
	result_t              result;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_ADDR_TIMEOUT)) begin
			timeout_q <= pwdata[TIMEOUT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_ADDR_TIMEOUT) ? {8'd0, timeout_q} : 32'd0;

	skpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.fq_stat   (fq_stat)
	);

	skpr_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_ready     (cmd_ready),
		.timeout_ticks (timeout_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.result        (result)
	);

	assign m_tdata = result;

	// an empty command queue always takes input
	a_front_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		fq_stat.empty |-> s_tready)
		else $error("command queue empty but input not ready");

	// a result without a report carries no keycode or modifier
	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !result.report_valid) |->
		(result.report_keycode == 8'd0 && result.report_modifier == 8'd0))
		else $error("report fields set without a report");

	// a release report has a zero modifier
	a_release_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result.report_valid && result.report_keycode == 8'd0) |->
		(result.report_modifier == 8'd0))
		else $error("release report with nonzero modifier");

	// the ring queue never holds more than depth minus one pairs
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((QUEUE_DEPTH > 64) ||
		(32'(result.queue_level) <= 32'(QUEUE_DEPTH - 1))))
		else $error("queue level beyond capacity");

endmodule
`default_nettype wire

// ===== sim/serial_key_pair_to_keyboard_report_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_key_pair_to_keyboard_report_core_tb: self-checking testbench
// Streams received bytes, time ticks and report service slots into the core
// and compares every output transfer field by field against a behavioral
// model of the key pairing, pair timeout, pair queue and press/release report
// sequencer. The pair timeout register is rewritten between phases, and
// both stream sides stall at random.
// ----------------------------------------------------------------------------
module serial_key_pair_to_keyboard_report_core_tb;
	import skpr_pkg::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {
		STG_IDLE,
		STG_PRESS,
		STG_RELEASE
	} report_stage_t;

	typedef struct {
		op_t        op;
		logic [7:0] data_byte;
		logic       host_ready;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] data_byte, [8] host_ready, [15:9] zero
	logic [1:0]  s_tuser = '0;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] report_valid, [8:1] report_keycode, [16:9] report_modifier,
	// [48:17] dropped_pairs, [54:49] queue_level, [55] pair_waiting
	logic [55:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	serial_key_pair_to_keyboard_report_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model state
	logic [TIMEOUT_W-1:0] timeout_ticks = TIMEOUT_RESET;
	logic                 half_pair = 1'b0;
	logic [7:0]           held_keycode = '0;
	logic [TIMEOUT_W-1:0] byte_age = '0;
	logic                 age_live = 1'b0;
	logic [15:0]          pair_ram [DEPTH];
	int                   wr_ptr = 0;
	int                   rd_ptr = 0;
	logic [DROP_W-1:0]    drop_total = '0;
	report_stage_t        stage = STG_IDLE;
	logic [15:0]          active_pair = '0;

	key_event_t pending_events[$];
	result_t    expected_reports[$];
	int         send_idle_pct = 19;
	int         recv_idle_pct = 51;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	result_t    got_report;
	result_t    want_report;

	function automatic result_t predict_report(op_t op, logic [7:0] b, logic ready);
		result_t r;
		int      nxt;
		r = '0;
		case (op)
			OP_BYTE: begin
				byte_age = '0;
				age_live = 1'b1;
				if (!half_pair) begin
					held_keycode = b;
					half_pair = 1'b1;
				end else begin
					if (held_keycode != 8'd0) begin
						nxt = (wr_ptr + 1) % DEPTH;
						if (nxt == rd_ptr) begin
							drop_total = drop_total + 1'b1;
						end else begin
							pair_ram[wr_ptr] = {b, held_keycode};
							wr_ptr = nxt;
						end
					end
					half_pair = 1'b0;
				end
			end
			OP_TICK: begin
				// advance first, then test the age against the timeout
				if (byte_age != AGE_MAX)
					byte_age = byte_age + 1'b1;
				if (half_pair && age_live && byte_age > timeout_ticks) begin
					half_pair = 1'b0;
					held_keycode = '0;
					age_live = 1'b0;
				end
			end
			OP_SLOT: begin
				if (stage == STG_PRESS || stage == STG_RELEASE) begin
					if (ready) begin
						r.report_valid = 1'b1;
						if (stage == STG_PRESS) begin
							r.report_keycode = active_pair[7:0];
							r.report_modifier = active_pair[15:8];
							stage = STG_RELEASE;
						end else begin
							stage = STG_IDLE;
						end
					end
				end else begin
					stage = STG_IDLE;
					if (rd_ptr != wr_ptr) begin
						active_pair = pair_ram[rd_ptr];
						rd_ptr = (rd_ptr + 1) % DEPTH;
						if (active_pair[7:0] != 8'd0)
							stage = STG_PRESS;
					end
				end
			end
			default: ;
		endcase
		r.dropped_pairs = drop_total;
		r.queue_level = LEVEL_W'((wr_ptr + DEPTH - rd_ptr) % DEPTH);
		r.pair_waiting = half_pair;
		return r;
	endfunction

	// driver: hold the item until its transfer, then present the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				expected_reports.push_back(predict_report(op_t'(s_tuser), s_tdata[7:0],
					s_tdata[8]));
			if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_events[0].op;
				s_tdata <= {7'd0, pending_events[0].host_ready, pending_events[0].data_byte};
				void'(pending_events.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got_report = result_t'(m_tdata);
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report: expected none, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want_report = expected_reports.pop_front();
				check_field("report_valid", want_report.report_valid, got_report.report_valid);
				check_field("report_keycode", want_report.report_keycode,
					got_report.report_keycode);
				check_field("report_modifier", want_report.report_modifier,
					got_report.report_modifier);
				check_field("dropped_pairs", want_report.dropped_pairs,
					got_report.dropped_pairs);
				check_field("queue_level", want_report.queue_level, got_report.queue_level);
				check_field("pair_waiting", want_report.pair_waiting, got_report.pair_waiting);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_event(op_t op, logic [7:0] b, logic ready);
		key_event_t ev;
		ev.op = op;
		ev.data_byte = b;
		ev.host_ready = ready;
		pending_events.push_back(ev);
	endtask

	task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ADDR_TIMEOUT;
		pwdata <= {8'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		timeout_ticks = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until every item is transferred and every report has arrived
	task automatic drain();
		do @(posedge clk);
		while (pending_events.size() != 0 || s_tvalid || expected_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// mostly key pairs with random content, mixed with slots, ticks and noise
	task automatic add_random_events(int count);
		int         added;
		int         pick;
		int         gap;
		logic [7:0] keycode;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				keycode = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
				add_event(OP_BYTE, keycode, 1'($urandom));
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				repeat (gap) add_event(OP_TICK, 8'($urandom), 1'($urandom));
				add_event(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom));
				added += gap + 2;
			end else if (pick < 55) begin
				add_event(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom));
				gap = $urandom_range(0, 4);
				repeat (gap) add_event(OP_TICK, 8'($urandom), 1'($urandom));
				added += gap + 1;
			end else if (pick < 85) begin
				add_event(OP_SLOT, 8'($urandom), ($urandom_range(0, 3) != 0));
				added++;
			end else if (pick < 95) begin
				add_event(OP_TICK, 8'($urandom), 1'($urandom));
				added++;
			end else begin
				add_event(OP_NOP, 8'($urandom), 1'($urandom));
				added++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_timeout(24'd2);

		// directed: extremes, zero keycode, timeout discard, host stalls
		add_event(OP_NOP, 8'hFF, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b0);
		add_event(OP_TICK, 8'h00, 1'b0);
		add_event(OP_BYTE, 8'hFF, 1'b0);
		add_event(OP_BYTE, 8'hFF, 1'b1);
		add_event(OP_BYTE, 8'h00, 1'b0);
		add_event(OP_BYTE, 8'h5A, 1'b0);
		add_event(OP_BYTE, 8'h01, 1'b0);
		add_event(OP_BYTE, 8'h00, 1'b0);
		add_event(OP_BYTE, 8'h80, 1'b0);
		repeat (3) add_event(OP_TICK, 8'h00, 1'b0);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b0);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b0);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_SLOT, 8'h00, 1'b1);
		add_event(OP_BYTE, 8'h3C, 1'b1);
		add_event(OP_NOP, 8'h00, 1'b0);
		add_event(OP_BYTE, 8'hC3, 1'b1);
		drain();

		write_timeout(24'd0);
		add_random_events(200);
		drain();

		// fill the pair queue past capacity so full-queue drops occur
		send_idle_pct = 51;
		recv_idle_pct = 19;
		write_timeout(AGE_MAX);
		repeat (65) begin
			add_event(OP_BYTE, 8'($urandom_range(1, 255)), 1'($urandom));
			add_event(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom));
		end
		add_random_events(100);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_timeout(24'd1);
		add_random_events(200);
		drain();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
